// File: rtl/core/lsbse_pkg.sv
// shared types and codes for the lsb stego extractor
// no dependencies; imported by lsbse_decoder and lsb_stego_extractor_unit
package lsbse_pkg;

    localparam int PIXEL_W = 24;
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;

    // result kind codes
    typedef enum logic [KIND_W-1:0] {
        KIND_NAME = 2'd0,
        KIND_TERM = 2'd1,
        KIND_SIZE = 2'd2,
        KIND_DATA = 2'd3
    } kind_t;

    // one decoded result, valid for the item being processed
    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } result_t;

endpackage

// File: rtl/core/lsbse_decoder.sv
// bit extraction and message framing state for the lsb stego extractor
// depends on lsbse_pkg; one item is decoded in the cycle that advance is high
module lsbse_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [lsbse_pkg::PIXEL_W-1:0] pixel_rgb,
    input  logic                          first_pixel,
    output lsbse_pkg::result_t            res
);
    import lsbse_pkg::*;

    typedef enum logic [1:0] {
        PH_NAME = 2'd0,
        PH_SIZE = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    phase_t        phase_reg, phase_next;
    logic [1:0]    channel_reg, channel_next;
    logic [2:0]    bit_cnt_reg, bit_cnt_next;
    logic [7:0]    byte_reg, byte_next;
    logic [31:0]   size_reg, size_next;
    logic [4:0]    size_cnt_reg, size_cnt_next;
    logic [34:0]   remain_reg, remain_next;

    // state as seen by this item, after a possible restart
    phase_t        phase_eff;
    logic [1:0]    channel_eff;
    logic [2:0]    bit_cnt_eff;
    logic [7:0]    byte_eff;
    logic [31:0]   size_eff;
    logic [4:0]    size_cnt_eff;
    logic [34:0]   remain_eff;

    logic          bit_in;
    logic [7:0]    byte_shifted;
    logic [31:0]   size_shifted;

    // restart clears everything before the pixel is decoded
    always_comb
    begin
        if (first_pixel)
        begin
            phase_eff    = PH_NAME;
            channel_eff  = 2'd0;
            bit_cnt_eff  = 3'd0;
            byte_eff     = 8'd0;
            size_eff     = 32'd0;
            size_cnt_eff = 5'd0;
            remain_eff   = 35'd0;
        end
        else
        begin
            phase_eff    = phase_reg;
            channel_eff  = channel_reg;
            bit_cnt_eff  = bit_cnt_reg;
            byte_eff     = byte_reg;
            size_eff     = size_reg;
            size_cnt_eff = size_cnt_reg;
            remain_eff   = remain_reg;
        end
    end

    // pick the lsb of red, green or blue
    always_comb
    begin
        case (channel_eff)
            2'd0:    bit_in = pixel_rgb[16];
            2'd1:    bit_in = pixel_rgb[8];
            default: bit_in = pixel_rgb[0];
        endcase
    end

    assign byte_shifted = {byte_eff[6:0], bit_in};
    assign size_shifted = {size_eff[30:0], bit_in};

    // next state and result for this item
    always_comb
    begin
        phase_next    = phase_eff;
        channel_next  = channel_eff;
        bit_cnt_next  = bit_cnt_eff;
        byte_next     = byte_eff;
        size_next     = size_eff;
        size_cnt_next = size_cnt_eff;
        remain_next   = remain_eff;
        res.valid     = 1'b0;
        res.kind      = KIND_NAME;
        res.value     = '0;
        res.last      = 1'b0;

        if (phase_eff != PH_DONE)
        begin
            channel_next = (channel_eff >= 2'd2) ? 2'd0 : channel_eff + 2'd1;
            if (phase_eff == PH_SIZE)
            begin
                size_next = size_shifted;
                if (size_cnt_eff == 5'd31)
                begin
                    size_cnt_next = 5'd0;
                    remain_next   = {size_shifted, 3'b000};
                    res.valid     = 1'b1;
                    res.kind      = KIND_SIZE;
                    res.value     = size_shifted;
                    res.last      = (size_shifted == 32'd0);
                    phase_next    = (size_shifted == 32'd0) ? PH_DONE : PH_DATA;
                end
                else
                begin
                    size_cnt_next = size_cnt_eff + 5'd1;
                end
            end
            else
            begin
                byte_next    = byte_shifted;
                bit_cnt_next = bit_cnt_eff + 3'd1;
                if (phase_eff == PH_DATA)
                begin
                    remain_next = remain_eff - 35'd1;
                end
                if (bit_cnt_eff == 3'd7)
                begin
                    byte_next = 8'd0;
                    res.valid = 1'b1;
                    res.value = {24'd0, byte_shifted};
                    if (phase_eff == PH_NAME)
                    begin
                        if (byte_shifted == 8'd0)
                        begin
                            res.kind   = KIND_TERM;
                            phase_next = PH_SIZE;
                        end
                        else
                        begin
                            res.kind = KIND_NAME;
                        end
                    end
                    else
                    begin
                        res.kind = KIND_DATA;
                        res.last = (remain_next == 35'd0);
                        if (remain_next == 35'd0)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                end
            end
        end

        if (!advance)
        begin
            res.valid = 1'b0;
        end
    end

    // framing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NAME;
            channel_reg  <= 2'd0;
            bit_cnt_reg  <= 3'd0;
            byte_reg     <= 8'd0;
            size_reg     <= 32'd0;
            size_cnt_reg <= 5'd0;
            remain_reg   <= 35'd0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            channel_reg  <= channel_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_reg     <= byte_next;
            size_reg     <= size_next;
            size_cnt_reg <= size_cnt_next;
            remain_reg   <= remain_next;
        end
    end

    // checks
    a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && (res.kind == KIND_NAME || res.kind == KIND_TERM) |-> !res.last)
        else $error("last flagged on a name result");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.last |=> phase_reg == PH_DONE)
        else $error("decoder not done after last result");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE && !(advance && first_pixel) |=> phase_reg == PH_DONE)
        else $error("decoder left done without a restart");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        channel_reg != 2'd3)
        else $error("channel select out of range");

endmodule

// File: rtl/core/lsb_stego_extractor_unit.sv
// top level of the lsb stego extractor: input register, decoder, result register
// depends on lsbse_pkg and lsbse_decoder
//
// usage:
//   pixels enter on the s_axis channel, one item per pixel in raster order;
//   s_axis_tuser marks the first pixel of an image and restarts decoding there.
//   each pixel gives one hidden bit (lsb of red, green, blue in rotation).
//   results leave on the m_axis channel: name bytes, the name terminator,
//   the 32-bit payload size, then payload bytes; tlast marks the final result.
//   pixels after the final result give nothing until a restart.
// order: an accepted pixel waits in the input register until the result
//   register is free; the decoder then steps and registers its result for m_axis.
// throughput: one pixel per cycle while the result register is free; the
//   decoder step is combinational between the input and result registers.
// stalls: when m_axis_tready is low with a result waiting, the decoder holds
//   and the input register holds one pixel; s_axis_tready drops once it does.
// reset: rst_n clears both registers' valid flags and the decoder state,
//   so decoding starts in the name phase on the red channel.
module lsb_stego_extractor_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lsbse_pkg::PIXEL_W-1:0] s_axis_tdata,   // [23:0] pixel_rgb
    input  logic                          s_axis_tuser,   // [0] first_pixel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lsbse_pkg::VALUE_W-1:0] m_axis_tdata,   // [31:0] value
    output logic [lsbse_pkg::KIND_W-1:0]  m_axis_tuser,   // [1:0] kind
    output logic                          m_axis_tlast    // last
);
    import lsbse_pkg::*;

    logic                in_valid_reg;
    logic [PIXEL_W-1:0]  in_pixel_reg;
    logic                in_first_reg;
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    kind_t               out_kind_reg;
    logic                out_last_reg;
    logic                out_free;
    logic                advance;
    result_t             res;

    // the held pixel is decoded when the result register can take a result
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    lsbse_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .pixel_rgb   (in_pixel_reg),
        .first_pixel (in_first_reg),
        .res         (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_pixel_reg <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_value_reg <= res.value;
            out_kind_reg  <= res.kind;
            out_last_reg  <= res.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // checks
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg)
        else $error("pending result dropped");

    a_result_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> in_valid_reg && out_free)
        else $error("result without a decoded item");

    a_input_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_pixel_reg))
        else $error("held pixel lost while stalled");

endmodule

// File: bench/tb_top.sv
// self-checking bench for lsb_stego_extractor_unit: pixels carrying hidden messages go in,
// decoded name, size and payload items are checked; depends on lsbse_pkg and the unit rtl
module tb_top;
    import lsbse_pkg::*;

    localparam int ITEM_TARGET   = 700;
    localparam int SETTLE_CYCLES = 8;
    localparam int RUN_LIMIT     = 400000;

    // decoding phases as the bench tracks them
    typedef enum logic [1:0] {
        ST_NAME = 2'd0,
        ST_SIZE = 2'd1,
        ST_DATA = 2'd2,
        ST_DONE = 2'd3
    } decode_phase_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] rgb;
        logic               first;
    } pixel_item_t;

    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } hidden_item_t;

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [PIXEL_W-1:0] s_axis_tdata  = '0;    // [23:0] pixel_rgb
    logic               s_axis_tuser  = 1'b0;  // [0] first_pixel
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [VALUE_W-1:0] m_axis_tdata;          // [31:0] value
    logic [KIND_W-1:0]  m_axis_tuser;          // [1:0] kind
    logic               m_axis_tlast;

    pixel_item_t  pending_pixels[$];
    hidden_item_t hidden_results[$];
    int           total_items;
    int           pixels_queued;
    int           pixels_sent;
    int           results_seen;
    int           messages_built;
    int           error_count;
    int           gen_channel;

    // mirrored decoder state
    decode_phase_t      dec_phase;
    logic [1:0]         dec_channel;
    logic [2:0]         dec_bit_cnt;
    logic [7:0]         dec_byte;
    logic [VALUE_W-1:0] dec_size;
    logic [4:0]         dec_size_bits;
    logic [34:0]        dec_bits_left;

    lsb_stego_extractor_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock and reset
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // hard stop in case the stream hangs
    initial
    begin
        #RUN_LIMIT;
        $display("tb_top: errors");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("tb_top: mismatch on result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    task automatic clear_decoder();
        dec_phase     = ST_NAME;
        dec_channel   = 2'd0;
        dec_bit_cnt   = 3'd0;
        dec_byte      = 8'd0;
        dec_size      = '0;
        dec_size_bits = 5'd0;
        dec_bits_left = 35'd0;
    endtask

    // advance the mirrored decoder by one accepted pixel
    task automatic decode_pixel(input logic [PIXEL_W-1:0] rgb, input logic first);
        logic         hidden;
        hidden_item_t res;
        if (first)
            clear_decoder();
        if (dec_phase == ST_DONE)
            return;
        case (dec_channel)
            2'd0:    hidden = rgb[16];
            2'd1:    hidden = rgb[8];
            default: hidden = rgb[0];
        endcase
        dec_channel = (dec_channel == 2'd2) ? 2'd0 : dec_channel + 2'd1;
        if (dec_phase == ST_SIZE)
        begin
            dec_size = {dec_size[VALUE_W-2:0], hidden};
            if (dec_size_bits == 5'd31)
            begin
                dec_size_bits = 5'd0;
                dec_bits_left = {dec_size, 3'b000};
                res.kind      = KIND_SIZE;
                res.value     = dec_size;
                res.last      = (dec_bits_left == 35'd0);
                hidden_results.push_back(res);
                dec_phase     = res.last ? ST_DONE : ST_DATA;
            end
            else
            begin
                dec_size_bits = dec_size_bits + 5'd1;
            end
        end
        else
        begin
            dec_byte    = {dec_byte[6:0], hidden};
            dec_bit_cnt = dec_bit_cnt + 3'd1;
            if (dec_phase == ST_DATA)
                dec_bits_left = dec_bits_left - 35'd1;
            if (dec_bit_cnt == 3'd0)
            begin
                res.value = {24'd0, dec_byte};
                res.last  = 1'b0;
                if (dec_phase == ST_NAME)
                begin
                    res.kind = (dec_byte == 8'd0) ? KIND_TERM : KIND_NAME;
                    if (dec_byte == 8'd0)
                        dec_phase = ST_SIZE;
                end
                else
                begin
                    res.kind = KIND_DATA;
                    res.last = (dec_bits_left == 35'd0);
                    if (res.last)
                        dec_phase = ST_DONE;
                end
                hidden_results.push_back(res);
                dec_byte = 8'd0;
            end
        end
    endtask

    // raw pixel with no hidden content planned
    task automatic queue_raw(input logic [PIXEL_W-1:0] rgb, input logic first, input bit counted);
        pixel_item_t item;
        item.rgb   = rgb;
        item.first = first;
        pending_pixels.push_back(item);
        if (counted)
            pixels_queued++;
    endtask

    // pixel with one hidden bit on the channel the decoder will read
    task automatic queue_bit(input logic hidden, input logic first);
        pixel_item_t item;
        if (first)
            gen_channel = 0;
        item.rgb   = PIXEL_W'($urandom);
        item.first = first;
        case (gen_channel)
            0:       item.rgb[16] = hidden;
            1:       item.rgb[8]  = hidden;
            default: item.rgb[0]  = hidden;
        endcase
        gen_channel = (gen_channel + 1) % 3;
        pending_pixels.push_back(item);
        pixels_queued++;
    endtask

    // one embedded message; keep_bytes below size or broken leaves it unfinished
    task automatic queue_message(input int name_len, input logic [31:0] size_bytes,
                                 input int keep_bytes, input bit broken);
        logic       msg_bits[$];
        logic [7:0] octet;
        int         total;
        for (int i = 0; i <= name_len; i++)
        begin
            case ($urandom_range(3))
                0:       octet = 8'h01;
                1:       octet = 8'hFF;
                default: octet = 8'($urandom_range(255, 1));
            endcase
            if (i == name_len)
                octet = 8'd0;
            for (int b = 7; b >= 0; b--)
                msg_bits.push_back(octet[b]);
        end
        for (int b = 31; b >= 0; b--)
            msg_bits.push_back(size_bytes[b]);
        for (int i = 0; i < keep_bytes; i++)
        begin
            octet = 8'($urandom);
            for (int b = 7; b >= 0; b--)
                msg_bits.push_back(octet[b]);
        end
        total = msg_bits.size();
        if (broken)
            total = $urandom_range(total - 1, 1);
        for (int i = 0; i < total; i++)
            queue_bit(msg_bits[i], i == 0);
        // pixels after a finished message should be ignored
        if (!broken && keep_bytes == int'(size_bytes))
        begin
            repeat ($urandom_range(5)) queue_raw(PIXEL_W'($urandom), 1'b0, 1'b0);
        end
        messages_built++;
    endtask

    function automatic int run_stage();
        int s;
        s = (total_items == 0) ? 0 : pixels_sent * 3 / total_items;
        return s;
    endfunction

    function automatic int sender_idle_pct();
        case (run_stage())
            0:       return 35;
            1:       return 67;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (run_stage())
            0:       return 67;
            1:       return 35;
            default: return 0;
        endcase
    endfunction

    // pixel driver, predicts on every accepted item
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= 1'b0;
            clear_decoder();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                decode_pixel(s_axis_tdata, s_axis_tuser);
                pixels_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_pixels.size() != 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_pixels[0].rgb;
                    s_axis_tuser  <= pending_pixels[0].first;
                    void'(pending_pixels.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (hidden_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item kind %0d value 0x%08h last %0b",
                                              m_axis_tuser, m_axis_tdata, m_axis_tlast));
                end
                else
                begin
                    if (m_axis_tuser !== hidden_results[0].kind)
                        report_mismatch($sformatf("kind %0d, expected %0d",
                                                  m_axis_tuser, hidden_results[0].kind));
                    if (m_axis_tdata !== hidden_results[0].value)
                        report_mismatch($sformatf("value 0x%08h, expected 0x%08h",
                                                  m_axis_tdata, hidden_results[0].value));
                    if (m_axis_tlast !== hidden_results[0].last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_axis_tlast, hidden_results[0].last));
                    void'(hidden_results.pop_front());
                end
            end
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // stimulus and end of run
    initial
    begin
        int pick;
        logic [31:0] size_bytes;
        total_items    = 0;
        pixels_queued  = 0;
        pixels_sent    = 0;
        results_seen   = 0;
        messages_built = 0;
        error_count    = 0;
        gen_channel    = 0;

        // from reset without a start flag: name byte 0xAC out of extreme pixels
        queue_raw(24'hFFFFFF, 1'b0, 1'b1);
        queue_raw(24'h000000, 1'b0, 1'b1);
        queue_raw(24'hFFFFFF, 1'b0, 1'b1);
        queue_raw(24'hFEFEFE, 1'b0, 1'b1);
        queue_raw(24'h010101, 1'b0, 1'b1);
        queue_raw(24'hFFFFFF, 1'b0, 1'b1);
        queue_raw(24'h000000, 1'b0, 1'b1);
        queue_raw(24'h000001, 1'b0, 1'b1);
        // restart on an all-zero pixel, eight zero bits give the terminator
        queue_raw(24'h000000, 1'b1, 1'b1);
        repeat (7) queue_raw(24'h000000, 1'b0, 1'b1);
        // size bits all ones, cut short by the next restart
        repeat (9) queue_raw(24'hFFFFFF, 1'b0, 1'b1);

        // empty name with zero size
        queue_message(0, 32'd0, 0, 1'b0);
        // long name
        queue_message(20, 32'd2, 2, 1'b0);
        // largest sizes, payload cut by a restart
        queue_message(1, 32'hFFFFFFFF, 3, 1'b0);
        queue_message(0, 32'h20000000, 2, 1'b0);
        queue_message(2, 32'd1, 1, 1'b0);

        while (pixels_queued < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
            begin
                size_bytes = ($urandom_range(4) == 0) ? 32'd0 : 32'($urandom_range(6, 1));
                queue_message($urandom_range(4), size_bytes, int'(size_bytes), 1'b0);
            end
            else if (pick < 90)
            begin
                size_bytes = ($urandom_range(1) == 0) ? 32'($urandom) : 32'($urandom_range(6));
                queue_message($urandom_range(4), size_bytes,
                              (size_bytes > 32'd6) ? 2 : int'(size_bytes), 1'b1);
            end
            else
            begin
                repeat ($urandom_range(20, 3))
                    queue_raw(PIXEL_W'($urandom), ($urandom_range(7) == 0), 1'b1);
            end
        end
        total_items = pending_pixels.size();

        wait (rst_n);
        while (pending_pixels.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (hidden_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("tb_top: %0d pixels driven over %0d embedded messages plus noise",
                 pixels_sent, messages_built);
        $display("tb_top: %0d decoded items checked under three idle patterns", results_seen);
        if (error_count == 0 && hidden_results.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// File: lsb_stego_extractor_unit.f
rtl/core/lsbse_pkg.sv
rtl/core/lsbse_decoder.sv
rtl/core/lsb_stego_extractor_unit.sv
bench/tb_top.sv
